### hw/rtl/ckt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counted key table package
// Transaction payloads, table entry layout and status codes.
// ----------------------------------------------------------------------------
package ckt_pkg;

    localparam logic       MODE_ADD       = 1'b0;
    localparam logic       MODE_REMOVE    = 1'b1;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_ABSENT  = 2'd2;

    localparam logic [7:0] COUNT_MAX      = 8'd255;
    localparam logic [7:0] COUNT_ONE      = 8'd1;

    typedef struct packed {
        logic       mode;
        logic [7:0] item_key;
        logic [3:0] item_slot;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] entry_position;
        logic [7:0] key_count;
        logic [4:0] entries_in_use;
    } t_res;

    typedef struct packed {
        logic [7:0] key;
        logic [7:0] count;
        logic [3:0] slot;
    } t_entry;

endpackage

### hw/rtl/ckt_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counted key table stream interface
// Valid/ready channel that carries one payload per transaction.
// ----------------------------------------------------------------------------
interface ckt_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/counted_key_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counted key table
// Table of keys with counts and slot tags, kept in order of first arrival.
//
//   Channel   Direction   Payload
//   i_req     in          mode, item_key, item_slot
//   o_res     out         status, entry_position, key_count, entries_in_use
//
// A transaction searches the entries in order (at least one search step, even on
// an empty table) and moves every later entry down after a deletion; the single
// compare and the one-read, one-write entry memory handle one entry at a time.
// After reset the table is empty; the entry memory is not cleared.
// A stalled result waits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module counted_key_table
    import ckt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ckt_stream_if.sink    i_req,
    ckt_stream_if.source  o_res
);

    localparam int AW = $clog2(CAPACITY);

    ckt_stream_if #(.T(t_res)) s_res ();

    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        rd_data;

    logic          r_out_valid;
    t_res          r_out;

    ckt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_res     (s_res),
        .o_rd_addr (rd_addr),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .i_rd_data (rd_data)
    );

    ckt_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign s_res.ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_res.valid && s_res.ready) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s_res.valid && s_res.ready) begin
            r_out <= s_res.data;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res.valid |-> !i_req.ready)
        else $error("Request accepted while a result is pending.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("Request accepted on two consecutive cycles.");

    a_fail_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.data.status == STATUS_FULL
                         || o_res.data.status == STATUS_ABSENT))
        |-> (o_res.data.key_count == 8'd0 && o_res.data.entry_position == 4'd0))
        else $error("Failed transaction reports a position or count.");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_res.valid && s_res.ready) |=> (o_res.valid && o_res.data == $past(s_res.data)))
        else $error("Output register did not take the finished result.");

endmodule

### hw/rtl/ckt_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counted key table entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ckt_mem
    import ckt_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/ckt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counted key table sequencer
// Walks the entries with one key comparator, updates counts, appends new
// entries and moves later entries down after a deletion.
// ----------------------------------------------------------------------------
module ckt_ctrl
    import ckt_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int AW      = $clog2(CAPACITY),
    localparam int UW      = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ckt_stream_if.sink           i_req,
    ckt_stream_if.source         o_res,
    output logic [AW-1:0]        o_rd_addr,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output t_entry               o_wr_data,
    input  t_entry               i_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    t_req          r_req,   n_req;
    logic [UW-1:0] r_idx,   n_idx;
    logic [UW-1:0] r_used,  n_used;
    logic [1:0]    r_status, n_status;
    logic [3:0]    r_pos,   n_pos;
    logic [7:0]    r_cnt,   n_cnt;

    logic [UW-1:0] idx_inc;
    logic          hit;
    logic          last;
    logic [AW+3:0] idx_ext;
    logic [AW+3:0] used_pos_ext;
    logic [UW+4:0] used_ext;

    assign idx_inc      = r_idx + UW'(1);
    assign hit          = (r_idx < r_used) && (i_rd_data.key == r_req.item_key);
    assign last         = idx_inc >= r_used;
    assign idx_ext      = {4'b0, r_idx[AW-1:0]};
    assign used_pos_ext = {4'b0, r_used[AW-1:0]};
    assign used_ext     = {5'b0, r_used};

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_idx     = r_idx;
        n_used    = r_used;
        n_status  = r_status;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx[AW-1:0];
        o_wr_data = i_rd_data;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.data;
                    n_idx   = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_status = STATUS_DONE;
                    n_pos    = idx_ext[3:0];
                    n_state  = S_DONE;
                    if (r_req.mode == MODE_ADD) begin
                        n_cnt = (i_rd_data.count == COUNT_MAX) ? COUNT_MAX
                                                               : i_rd_data.count + 8'd1;
                        o_wr_en         = 1'b1;
                        o_wr_data.count = n_cnt;
                    end else if (i_rd_data.count > COUNT_ONE) begin
                        n_cnt           = i_rd_data.count - 8'd1;
                        o_wr_en         = 1'b1;
                        o_wr_data.count = n_cnt;
                    end else begin
                        n_cnt  = '0;
                        n_used = r_used - UW'(1);
                        if (idx_inc < r_used) begin
                            n_idx   = idx_inc;
                            n_state = S_SHIFT;
                        end
                    end
                end else if (last) begin
                    n_pos   = '0;
                    n_cnt   = '0;
                    n_state = S_DONE;
                    if (r_req.mode == MODE_REMOVE) begin
                        n_status = STATUS_ABSENT;
                    end else if (r_used >= UW'(CAPACITY)) begin
                        n_status = STATUS_FULL;
                    end else begin
                        n_status  = STATUS_DONE;
                        n_pos     = used_pos_ext[3:0];
                        n_cnt     = COUNT_ONE;
                        n_used    = r_used + UW'(1);
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_used[AW-1:0];
                        o_wr_data = '{key: r_req.item_key, count: COUNT_ONE,
                                      slot: r_req.item_slot};
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_SHIFT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_idx - UW'(1));
                o_wr_data = i_rd_data;
                if (r_idx < r_used) begin
                    n_idx = idx_inc;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_cnt    <= n_cnt;
    end

    assign o_rd_addr   = n_idx[AW-1:0];
    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = (r_state == S_DONE);
    assign o_res.data  = '{status: r_status, entry_position: r_pos, key_count: r_cnt,
                          entries_in_use: used_ext[4:0]};

endmodule

### tb/sv/counted_key_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counted key table testbench
// Drives add and remove requests through the request channel and scores each
// response against a local model of the table. Directed tests cover appends,
// counting, deletion with compaction, the full table and count saturation.
// Random traffic then runs over a small key pool under several idle and stall
// patterns on both channels.
// ----------------------------------------------------------------------------
module counted_key_table_tb;
    import ckt_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_WAIT = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ckt_stream_if #(.T(t_req)) req_if ();
    ckt_stream_if #(.T(t_res)) res_if ();

    counted_key_table #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    t_entry table_entries[CAPACITY];
    int     table_used = 0;
    t_res   expected_results[$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int cycle_count     = 0;
    int mismatch_count  = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int full_seen       = 0;
    int absent_seen     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_res predict_table_op(input t_req req);
        t_res res;
        int   pos;
        bit   found;
        res   = '0;
        pos   = 0;
        found = 1'b0;
        for (int i = 0; i < table_used; i++) begin
            if (!found && table_entries[i].key == req.item_key) begin
                found = 1'b1;
                pos   = i;
            end
        end
        res.status = STATUS_DONE;
        if (req.mode == MODE_ADD) begin
            if (found) begin
                if (table_entries[pos].count != COUNT_MAX) begin
                    table_entries[pos].count = table_entries[pos].count + 8'd1;
                end
                res.entry_position = 4'(pos);
                res.key_count      = table_entries[pos].count;
            end else if (table_used >= CAPACITY) begin
                res.status = STATUS_FULL;
            end else begin
                table_entries[table_used].key   = req.item_key;
                table_entries[table_used].count = COUNT_ONE;
                table_entries[table_used].slot  = req.item_slot;
                res.entry_position = 4'(table_used);
                res.key_count      = COUNT_ONE;
                table_used++;
            end
        end else begin
            if (!found) begin
                res.status = STATUS_ABSENT;
            end else if (table_entries[pos].count > COUNT_ONE) begin
                table_entries[pos].count = table_entries[pos].count - 8'd1;
                res.entry_position = 4'(pos);
                res.key_count      = table_entries[pos].count;
            end else begin
                for (int j = pos; j + 1 < table_used; j++) begin
                    table_entries[j] = table_entries[j + 1];
                end
                table_used--;
                res.entry_position = 4'(pos);
                res.key_count      = 8'd0;
            end
        end
        res.entries_in_use = 5'(table_used);
        return res;
    endfunction

    task automatic log_mismatch(input string what, input t_res want, input t_res got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: expected st=%0d pos=%0d cnt=%0d used=%0d,",
                     $realtime, what, want.status, want.entry_position, want.key_count,
                     want.entries_in_use);
            $display("    got st=%0d pos=%0d cnt=%0d used=%0d",
                     got.status, got.entry_position, got.key_count, got.entries_in_use);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            expected_results.push_back(predict_table_op(req_if.data));
            requests_sent++;
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            results_checked++;
            if (got.status == STATUS_FULL) begin
                full_seen++;
            end
            if (got.status == STATUS_ABSENT) begin
                absent_seen++;
            end
            if (expected_results.size() == 0) begin
                log_mismatch("unexpected transaction", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status
                        || got.entry_position !== want.entry_position
                        || got.key_count !== want.key_count
                        || got.entries_in_use !== want.entries_in_use) begin
                    log_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    task automatic send_req(input logic mode, input logic [7:0] key, input logic [3:0] slot);
        t_req req;
        req.mode      = mode;
        req.item_key  = key;
        req.item_slot = slot;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= req;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
    endtask

    task automatic wait_all_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_append_and_delete();
        send_req(MODE_ADD, 8'h00, 4'h0);
        send_req(MODE_ADD, 8'hFF, 4'hF);
        send_req(MODE_ADD, 8'h00, 4'h5);
        send_req(MODE_REMOVE, 8'h5A, 4'hA);
        send_req(MODE_REMOVE, 8'hFF, 4'h0);
        send_req(MODE_REMOVE, 8'h00, 4'hF);
        send_req(MODE_REMOVE, 8'h00, 4'h0);
        send_req(MODE_REMOVE, 8'h00, 4'h3);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < CAPACITY; i++) begin
            send_req(MODE_ADD, 8'h10 + 8'(i), 4'(i));
        end
        send_req(MODE_ADD, 8'hAA, 4'h9);
        send_req(MODE_ADD, 8'h13, 4'h1);
        send_req(MODE_REMOVE, 8'h17, 4'h2);
        send_req(MODE_REMOVE, 8'h10, 4'h4);
        send_req(MODE_ADD, 8'hAA, 4'hC);
    endtask

    task automatic test_count_saturation();
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        for (int n = 0; n < 257; n++) begin
            send_req(MODE_ADD, 8'hC3, 4'($urandom_range(15)));
        end
        send_req(MODE_REMOVE, 8'hC3, 4'h0);
        wait_all_results();
    endtask

    task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
        int         pool_base;
        int         add_pct;
        logic       mode;
        logic [7:0] key;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        pool_base      = $urandom_range(232);
        for (int n = 0; n < items; n++) begin
            add_pct = (n < items / 2) ? 65 : 35;
            if ($urandom_range(99) < 88) begin
                key = 8'(pool_base + $urandom_range(23));
            end else begin
                key = 8'($urandom_range(255));
            end
            mode = ($urandom_range(99) < add_pct) ? MODE_ADD : MODE_REMOVE;
            send_req(mode, key, 4'($urandom_range(15)));
            if ($urandom_range(199) == 0) begin
                wait_all_results();
            end
        end
        wait_all_results();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_append_and_delete();
        test_full_table();
        test_count_saturation();
        test_random_traffic(450, 0, 0);
        test_random_traffic(450, 60, 0);
        test_random_traffic(450, 0, 60);
        test_random_traffic(450, 37, 37);

        wait_all_results();
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("Ran %0d requests and checked %0d responses under four idle patterns.",
                 requests_sent, results_checked);
        $display("Saw %0d full-table rejects and %0d absent-key removes, %0d mismatches.",
                 full_seen, absent_seen, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d responses never arrived.", expected_results.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/ckt_pkg.sv
hw/rtl/ckt_stream_if.sv
hw/rtl/ckt_mem.sv
hw/rtl/ckt_ctrl.sv
hw/rtl/counted_key_table.sv
tb/sv/counted_key_table_tb.sv
